>>> design/tqe_pkg.sv
// tqe_pkg: shared types, codes and helpers for the team queue engine
// no dependencies; imported by the interfaces and every module

package tqe_pkg;

    localparam int unsigned DEF_GROUPS         = 16;
    localparam int unsigned DEF_MEMBER_ENTRIES = 64;
    localparam int unsigned DEF_QUEUE_DEPTH    = 256;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned ELEM_W   = 32;
    localparam int unsigned GID_W    = 4;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ENQUEUE = 2'd1,
        FUNC_DEQUEUE = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_UNKNOWN = 2'd2,
        STATUS_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEMBER,
        ST_ENQ_WRITE,
        ST_ENQ_LINK,
        ST_DEQ_GROUP,
        ST_DEQ_SLOT,
        ST_DEQ_RETIRE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic load;
        logic clear;
    } member_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic full;
    } member_rsp_t;

    typedef struct packed {
        logic peek;
        logic rd;
        logic alloc;
        logic free;
        logic link_wr;
        logic clear;
    } store_ctl_t;

    typedef struct packed {
        logic rd_ring;
        logic rd_front;
        logic rd_sel;
        logic attach;
        logic detach;
        logic clear;
    } group_ctl_t;

    // group id modulo n by restoring subtraction, four narrow steps
    function automatic logic [GID_W-1:0] reduce_gid(input logic [GID_W-1:0] g,
                                                     input int unsigned n);
        int unsigned r;
        int k;
        r = int'(g);
        for (k = GID_W - 1; k >= 0; k--)
        begin
            if (r >= (n << k))
            begin
                r = r - (n << k);
            end
        end
        return GID_W'(r);
    endfunction

endpackage

>>> design/tqe_cmd_if.sv
// tqe_cmd_if: command channel, valid/ready with the command word
// depends on tqe_pkg for field widths

interface tqe_cmd_if;
    import tqe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [ELEM_W-1:0] element_value;
    logic [GID_W-1:0]         group_id;

    modport source (output valid, output func, output element_value, output group_id,
                    input ready);
    modport sink   (input valid, input func, input element_value, input group_id,
                    output ready);
endinterface

>>> design/tqe_rsp_if.sv
// tqe_rsp_if: result channel, valid/ready with the result word
// depends on tqe_pkg for field widths

interface tqe_rsp_if;
    import tqe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_out;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output element_out, output status, input ready);
    modport sink   (input valid, input element_out, input status, output ready);
endinterface

>>> design/tqe_member.sv
// tqe_member: membership table memory with a one-entry-per-cycle search
// and the load update; depends on tqe_pkg

module tqe_member #(
    parameter int unsigned MEMBER_ENTRIES = 64,
    parameter int unsigned GROUPS         = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tqe_pkg::member_ctl_t             ctl,
    input  logic [tqe_pkg::ELEM_W-1:0]       key,
    input  logic [$clog2(GROUPS)-1:0]        gid,
    output tqe_pkg::member_rsp_t             rsp,
    output logic [$clog2(GROUPS)-1:0]        group
);
    import tqe_pkg::*;

    localparam int unsigned MW = $clog2(MEMBER_ENTRIES);
    localparam int unsigned CW = MW + 1;
    localparam int unsigned GW = $clog2(GROUPS);

    logic [ELEM_W-1:0] value_mem [MEMBER_ENTRIES];
    logic [GW-1:0]     group_mem [MEMBER_ENTRIES];
    logic [ELEM_W-1:0] val_q;
    logic [GW-1:0]     grp_q;

    logic              busy_reg, busy_next;
    logic              load_reg, load_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     iss_reg, iss_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [MW-1:0]     pidx_reg, pidx_next;
    logic [ELEM_W-1:0] key_reg, key_next;
    logic [GW-1:0]     gid_reg, gid_next;

    logic              hit;
    logic              miss;
    logic              issue;
    logic              room;
    logic              wr_en;
    logic [MW-1:0]     wr_addr;

    always_comb
    begin
        hit     = busy_reg && pend_reg && (val_q == key_reg);
        miss    = busy_reg && !pend_reg && (iss_reg >= count_reg);
        issue   = busy_reg && !hit && !miss && (iss_reg < count_reg);
        room    = count_reg < CW'(MEMBER_ENTRIES);
        wr_en   = load_reg && (hit || (miss && room));
        wr_addr = hit ? pidx_reg : count_reg[MW-1:0];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        load_next  = load_reg;
        pend_next  = 1'b0;
        iss_next   = iss_reg;
        count_next = count_reg;
        pidx_next  = pidx_reg;
        key_next   = key_reg;
        gid_next   = gid_reg;
        if (ctl.clear)
        begin
            busy_next  = 1'b0;
            count_next = '0;
        end
        else if (ctl.start)
        begin
            busy_next = 1'b1;
            load_next = ctl.load;
            iss_next  = '0;
            key_next  = key;
            gid_next  = gid;
        end
        else
        begin
            if (hit || miss)
            begin
                busy_next = 1'b0;
            end
            if (issue)
            begin
                pend_next = 1'b1;
                pidx_next = iss_reg[MW-1:0];
                iss_next  = iss_reg + CW'(1);
            end
            if (load_reg && miss && room)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            load_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            iss_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            load_reg  <= load_next;
            pend_reg  <= pend_next;
            iss_reg   <= iss_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        key_reg  <= key_next;
        gid_reg  <= gid_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= key_reg;
            group_mem[wr_addr] <= gid_reg;
        end
        if (issue)
        begin
            val_q <= value_mem[iss_reg[MW-1:0]];
            grp_q <= group_mem[iss_reg[MW-1:0]];
        end
    end

    assign rsp.done = hit || miss;
    assign rsp.hit  = hit;
    assign rsp.full = load_reg && miss && !room;
    assign group    = grp_q;

endmodule

>>> design/tqe_store.sv
// tqe_store: element and link memories with the free list
// never-used slots come from a fill counter, recycled slots from a lifo chain

module tqe_store #(
    parameter int unsigned QUEUE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tqe_pkg::store_ctl_t               ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    addr,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    link_data,
    input  logic [tqe_pkg::ELEM_W-1:0]        value,
    output logic [tqe_pkg::ELEM_W-1:0]        elem_q,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    next_q,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    slot,
    output logic                              empty
);
    import tqe_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW:0] NULL_LINK = {1'b1, {AW{1'b0}}};

    logic [ELEM_W-1:0] elem_mem [QUEUE_DEPTH];
    logic [AW:0]       link_mem [QUEUE_DEPTH];
    logic [AW:0]       link_q;

    logic [AW:0]       head_reg, head_next;
    logic [AW:0]       fresh_reg, fresh_next;

    logic              link_we;
    logic [AW-1:0]     link_wa;
    logic [AW:0]       link_wd;
    logic              link_re;
    logic [AW-1:0]     link_ra;

    always_comb
    begin
        slot  = head_reg[AW] ? fresh_reg[AW-1:0] : head_reg[AW-1:0];
        empty = head_reg[AW] && (fresh_reg == (AW+1)'(QUEUE_DEPTH));

        link_we = ctl.alloc || ctl.free || ctl.link_wr;
        link_wa = ctl.alloc ? slot : addr;
        if (ctl.alloc)
        begin
            link_wd = NULL_LINK;
        end
        else if (ctl.free)
        begin
            link_wd = head_reg;
        end
        else
        begin
            link_wd = {1'b0, link_data};
        end
        link_re = ctl.peek || ctl.rd;
        link_ra = ctl.peek ? head_reg[AW-1:0] : addr;
    end

    always_comb
    begin
        head_next  = head_reg;
        fresh_next = fresh_reg;
        if (ctl.clear)
        begin
            head_next  = NULL_LINK;
            fresh_next = '0;
        end
        else if (ctl.alloc)
        begin
            if (head_reg[AW])
            begin
                fresh_next = fresh_reg + (AW+1)'(1);
            end
            else
            begin
                head_next = link_q;
            end
        end
        else if (ctl.free)
        begin
            head_next = {1'b0, addr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NULL_LINK;
            fresh_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (link_re)
        begin
            link_q <= link_mem[link_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.alloc)
        begin
            elem_mem[slot] <= value;
        end
        if (ctl.rd)
        begin
            elem_q <= elem_mem[addr];
        end
    end

    assign next_q = link_q[AW-1:0];

endmodule

>>> design/tqe_group.sv
// tqe_group: per-group head and tail memories, waiting flags and the
// group-order ring; depends on tqe_pkg

module tqe_group #(
    parameter int unsigned GROUPS      = 16,
    parameter int unsigned QUEUE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tqe_pkg::group_ctl_t               ctl,
    input  logic [$clog2(GROUPS)-1:0]         sel,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    slot,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]    nxt,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    head_q,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    tail_q,
    output logic                              sel_waiting,
    output logic                              ring_empty
);
    import tqe_pkg::*;

    localparam int unsigned GW = $clog2(GROUPS);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    logic [AW-1:0]     head_mem [GROUPS];
    logic [AW-1:0]     tail_mem [GROUPS];
    logic [GW-1:0]     ring_mem [GROUPS];
    logic [GW-1:0]     ring_q;

    logic [GROUPS-1:0] waiting_reg, waiting_next;
    logic [GW-1:0]     oh_reg, oh_next;
    logic [GW:0]       oc_reg, oc_next;
    logic [GW-1:0]     front_reg;

    logic              last;
    logic [GW+1:0]     push_sum;
    logic [GW-1:0]     push_idx;
    logic              ring_we;
    logic              head_we;
    logic [GW-1:0]     head_wa;
    logic [AW-1:0]     head_wd;
    logic              grp_re;
    logic [GW-1:0]     grp_ra;

    always_comb
    begin
        sel_waiting = waiting_reg[sel];
        ring_empty  = (oc_reg == '0);
        last        = (head_q == tail_q);
        push_sum    = (GW+2)'(oh_reg) + (GW+2)'(oc_reg);
        if (push_sum >= (GW+2)'(GROUPS))
        begin
            push_idx = GW'(push_sum - (GW+2)'(GROUPS));
        end
        else
        begin
            push_idx = GW'(push_sum);
        end
        ring_we = ctl.attach && !sel_waiting && (oc_reg < (GW+1)'(GROUPS));
        head_we = (ctl.attach && !sel_waiting) || (ctl.detach && !last);
        head_wa = ctl.attach ? sel : front_reg;
        head_wd = ctl.attach ? slot : nxt;
        grp_re  = ctl.rd_front || ctl.rd_sel;
        grp_ra  = ctl.rd_front ? ring_q : sel;
    end

    always_comb
    begin
        waiting_next = waiting_reg;
        oh_next      = oh_reg;
        oc_next      = oc_reg;
        if (ctl.clear)
        begin
            waiting_next = '0;
            oh_next      = '0;
            oc_next      = '0;
        end
        else if (ctl.attach)
        begin
            waiting_next[sel] = 1'b1;
            if (ring_we)
            begin
                oc_next = oc_reg + (GW+1)'(1);
            end
        end
        else if (ctl.detach && last)
        begin
            waiting_next[front_reg] = 1'b0;
            oh_next = (oh_reg == GW'(GROUPS - 1)) ? '0 : oh_reg + GW'(1);
            oc_next = oc_reg - (GW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= '0;
            oh_reg      <= '0;
            oc_reg      <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            oh_reg      <= oh_next;
            oc_reg      <= oc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_front)
        begin
            front_reg <= ring_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        if (ctl.attach)
        begin
            tail_mem[sel] <= slot;
        end
        if (grp_re)
        begin
            head_q <= head_mem[grp_ra];
            tail_q <= tail_mem[grp_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[push_idx] <= sel;
        end
        if (ctl.rd_ring)
        begin
            ring_q <= ring_mem[oh_reg];
        end
    end

endmodule

>>> design/team_queue_engine.sv
// team_queue_engine: top level, command sequencer and result register
// depends on tqe_pkg, tqe_cmd_if, tqe_rsp_if, tqe_member, tqe_store, tqe_group

// Team queue: load entries map element values to groups, an enqueue joins its group's
// run or puts the group at the back of the group order, a dequeue returns the head
// element of the front group. One command is worked at a time and the command channel
// is ready only between commands; a finished word waits in the result register while
// the next command is taken. Membership lookup walks the table one entry a cycle through
// the single member memory read port, up to the match or to the fill count on a miss; a
// load or a failed enqueue then goes to the result register, a successful enqueue first
// writes the element and attaches it to its group, and an enqueue into a waiting group
// also links it behind the group's tail. A dequeue reads in turn the ring, the group
// memories and the element and link memories, then retires the slot; a clear or a dequeue
// of an empty queue goes straight to the result register. Reset and clear need no sweep.

module team_queue_engine #(
    parameter int unsigned GROUPS         = tqe_pkg::DEF_GROUPS,
    parameter int unsigned MEMBER_ENTRIES = tqe_pkg::DEF_MEMBER_ENTRIES,
    parameter int unsigned QUEUE_DEPTH    = tqe_pkg::DEF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    tqe_cmd_if.sink   cmd,
    tqe_rsp_if.source rsp
);
    import tqe_pkg::*;

    localparam int unsigned GW = $clog2(GROUPS);
    localparam int unsigned AW = $clog2(QUEUE_DEPTH);

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [ELEM_W-1:0] val_reg, val_next;
    logic [GW-1:0]     g_reg, g_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [ELEM_W-1:0] res_elem_reg, res_elem_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] out_elem_reg, out_elem_next;
    status_t           out_status_reg, out_status_next;

    logic              accept;

    member_ctl_t       member_ctl;
    member_rsp_t       member_rsp;
    logic [GW-1:0]     member_group;
    logic [GW-1:0]     cmd_gid;

    store_ctl_t        store_ctl;
    logic [AW-1:0]     store_addr;
    logic [ELEM_W-1:0] store_elem;
    logic [AW-1:0]     store_next;
    logic [AW-1:0]     store_slot;
    logic              store_empty;

    group_ctl_t        group_ctl;
    logic [GW-1:0]     group_sel;
    logic [AW-1:0]     head_q;
    logic [AW-1:0]     tail_q;
    logic              sel_waiting;
    logic              ring_empty;

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign accept          = cmd.valid && cmd.ready;
    assign cmd_gid         = GW'(reduce_gid(cmd.group_id, GROUPS));
    assign group_sel       = (state_reg == ST_MEMBER) ? member_group : g_reg;
    assign store_addr      = (state_reg == ST_ENQ_LINK) ? tail_q : head_q;

    assign rsp.valid       = out_valid_reg;
    assign rsp.element_out = out_elem_reg;
    assign rsp.status      = out_status_reg;

    tqe_member #(
        .MEMBER_ENTRIES (MEMBER_ENTRIES),
        .GROUPS         (GROUPS)
    ) u_member (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (member_ctl),
        .key   (cmd.element_value),
        .gid   (cmd_gid),
        .rsp   (member_rsp),
        .group (member_group)
    );

    tqe_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (store_ctl),
        .addr      (store_addr),
        .link_data (slot_reg),
        .value     (val_reg),
        .elem_q    (store_elem),
        .next_q    (store_next),
        .slot      (store_slot),
        .empty     (store_empty)
    );

    tqe_group #(
        .GROUPS      (GROUPS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_group (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (group_ctl),
        .sel         (group_sel),
        .slot        (store_slot),
        .nxt         (store_next),
        .head_q      (head_q),
        .tail_q      (tail_q),
        .sel_waiting (sel_waiting),
        .ring_empty  (ring_empty)
    );

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        val_next        = val_reg;
        g_next          = g_reg;
        slot_next       = slot_reg;
        res_elem_next   = res_elem_reg;
        res_status_next = res_status_reg;
        out_elem_next   = out_elem_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        member_ctl      = '0;
        store_ctl       = '0;
        group_ctl       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next     = func_t'(cmd.func);
                    val_next      = cmd.element_value;
                    res_elem_next = '0;
                    case (func_t'(cmd.func))
                        FUNC_LOAD, FUNC_ENQUEUE:
                        begin
                            member_ctl.start = 1'b1;
                            member_ctl.load  = (func_t'(cmd.func) == FUNC_LOAD);
                            state_next       = ST_MEMBER;
                        end
                        FUNC_DEQUEUE:
                        begin
                            if (ring_empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                                state_next      = ST_RESP;
                            end
                            else
                            begin
                                group_ctl.rd_ring = 1'b1;
                                state_next        = ST_DEQ_GROUP;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            member_ctl.clear = 1'b1;
                            store_ctl.clear  = 1'b1;
                            group_ctl.clear  = 1'b1;
                            res_status_next  = STATUS_OK;
                            state_next       = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MEMBER:
            begin
                if (member_rsp.done)
                begin
                    state_next = ST_RESP;
                    if (func_reg == FUNC_LOAD)
                    begin
                        res_status_next = member_rsp.full ? STATUS_FULL : STATUS_OK;
                    end
                    else if (!member_rsp.hit)
                    begin
                        res_status_next = STATUS_UNKNOWN;
                    end
                    else if (store_empty)
                    begin
                        res_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        g_next           = member_group;
                        group_ctl.rd_sel = 1'b1;
                        store_ctl.peek   = 1'b1;
                        state_next       = ST_ENQ_WRITE;
                    end
                end
            end
            ST_ENQ_WRITE:
            begin
                store_ctl.alloc  = 1'b1;
                group_ctl.attach = 1'b1;
                slot_next        = store_slot;
                res_status_next  = STATUS_OK;
                state_next       = sel_waiting ? ST_ENQ_LINK : ST_RESP;
            end
            ST_ENQ_LINK:
            begin
                store_ctl.link_wr = 1'b1;
                state_next        = ST_RESP;
            end
            ST_DEQ_GROUP:
            begin
                group_ctl.rd_front = 1'b1;
                state_next         = ST_DEQ_SLOT;
            end
            ST_DEQ_SLOT:
            begin
                store_ctl.rd = 1'b1;
                state_next   = ST_DEQ_RETIRE;
            end
            ST_DEQ_RETIRE:
            begin
                group_ctl.detach = 1'b1;
                store_ctl.free   = 1'b1;
                res_elem_next    = store_elem;
                res_status_next  = STATUS_OK;
                state_next       = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_elem_next   = res_elem_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        val_reg        <= val_next;
        g_reg          <= g_next;
        slot_reg       <= slot_next;
        res_elem_reg   <= res_elem_next;
        res_status_reg <= res_status_next;
        out_elem_reg   <= out_elem_next;
        out_status_reg <= out_status_next;
    end

endmodule
